// File: rtl/assert_macros.svh
// Assertion macros for the allocator RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset.
`define SFLA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define SFLA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SFLA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFLA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/sfla_pkg.sv
// Shared types and constants of the segregated free-list allocator.
// No dependencies; imported by every allocator module.
package sfla_pkg;

    localparam int NUM_CLASSES      = 16;
    localparam int BLOCKS_PER_CLASS = 1024;
    localparam int CLASS_STEP       = 8;

    localparam int TOTAL_BLOCKS = NUM_CLASSES * BLOCKS_PER_CLASS;
    localparam int MAX_BYTES    = NUM_CLASSES * CLASS_STEP;

    localparam int CLS_W      = $clog2(NUM_CLASSES);
    localparam int IDX_W      = $clog2(BLOCKS_PER_CLASS);
    localparam int LINK_W     = $clog2(BLOCKS_PER_CLASS + 1);
    localparam int HANDLE_W   = 14;
    localparam int REQ_SIZE_W = 12;
    localparam int REQ_HDL_W  = 15;
    localparam int BYTES_W    = 8;

    // Null link: one past the last index of a class.
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(BLOCKS_PER_CLASS);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_BAD_SIZE  = 2'd2,
        ST_IGNORED   = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode                 opcode;
        logic [REQ_SIZE_W-1:0]   request_size;
        logic [REQ_HDL_W-1:0]    block_handle;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic [HANDLE_W-1:0]     handle;
        logic [BYTES_W-1:0]      class_bytes;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_DECODE = 2'd1,
        S_POP    = 2'd2
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic    load_req;
        logic    rd_link;
        logic    take_fresh;
        logic    take_pop;
        logic    push;
        logic    fail;
        t_status fail_status;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_free;
        logic size_ok;
        logic handle_ok;
        logic head_valid;
        logic fresh_avail;
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/sfla_ctrl.sv
// Request sequencer of the allocator: accept, decode, optional link pop.
// Depends on sfla_pkg for the state enum and command/status structs.
module sfla_ctrl import sfla_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_sts.is_free && i_sts.size_ok && i_sts.head_valid) begin
                    n_state = S_POP;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready    = 1'b1;
                o_cmd.load_req = i_req_valid;
            end
            S_DECODE: begin
                if (i_sts.is_free) begin
                    if (i_sts.out_free) begin
                        if (i_sts.handle_ok) begin
                            o_cmd.push = 1'b1;
                        end else begin
                            o_cmd.fail        = 1'b1;
                            o_cmd.fail_status = ST_IGNORED;
                        end
                    end
                end else if (!i_sts.size_ok) begin
                    if (i_sts.out_free) begin
                        o_cmd.fail        = 1'b1;
                        o_cmd.fail_status = ST_BAD_SIZE;
                    end
                end else if (i_sts.head_valid) begin
                    // fetch the head's link; the pop commits next state
                    o_cmd.rd_link = 1'b1;
                end else if (i_sts.out_free) begin
                    if (i_sts.fresh_avail) begin
                        o_cmd.take_fresh = 1'b1;
                    end else begin
                        o_cmd.fail        = 1'b1;
                        o_cmd.fail_status = ST_EXHAUSTED;
                    end
                end
            end
            S_POP: begin
                o_cmd.take_pop = i_sts.out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/sfla_dp.sv
// Allocator datapath: request latch, per-class head and bump registers,
// block link memory and result register. Depends on sfla_pkg.
module sfla_dp import sfla_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_req    i_req,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output logic    o_rsp_valid,
    input  logic    i_rsp_ready,
    output t_rsp    o_rsp
);

    t_req                  r_req;
    logic [LINK_W-1:0]     r_head  [NUM_CLASSES];
    logic [LINK_W-1:0]     r_fresh [NUM_CLASSES];
    logic [LINK_W-1:0]     r_link_mem [TOTAL_BLOCKS];
    logic [LINK_W-1:0]     r_link_rd;
    logic                  r_rsp_valid;
    logic                  n_rsp_valid;
    t_rsp                  r_rsp;

    logic [REQ_SIZE_W-1:0] size_m1;
    logic [CLS_W-1:0]      alloc_cls;
    logic [CLS_W-1:0]      free_cls;
    logic [IDX_W-1:0]      free_idx;
    logic [CLS_W-1:0]      cls;
    logic [LINK_W-1:0]     head;
    logic [LINK_W-1:0]     fresh;
    logic [HANDLE_W-1:0]   link_addr;
    logic [HANDLE_W-1:0]   fresh_handle;
    logic [BYTES_W-1:0]    cls_bytes;
    logic                  out_load;

    always_comb begin
        size_m1   = r_req.request_size - REQ_SIZE_W'(1);
        alloc_cls = CLS_W'(size_m1 / CLASS_STEP);
        free_cls  = CLS_W'(r_req.block_handle / BLOCKS_PER_CLASS);
        free_idx  = IDX_W'(r_req.block_handle % BLOCKS_PER_CLASS);
        cls       = (r_req.opcode == OP_FREE) ? free_cls : alloc_cls;
        head      = r_head[cls];
        fresh     = r_fresh[cls];
        link_addr    = HANDLE_W'(32'(cls) * BLOCKS_PER_CLASS + 32'(head[IDX_W-1:0]));
        fresh_handle = HANDLE_W'(32'(cls) * BLOCKS_PER_CLASS + 32'(fresh[IDX_W-1:0]));
        cls_bytes    = BYTES_W'((32'(cls) + 1) * CLASS_STEP);
    end

    always_comb begin
        o_sts.is_free     = (r_req.opcode == OP_FREE);
        o_sts.size_ok     = (r_req.request_size != '0) && (32'(size_m1) < MAX_BYTES);
        o_sts.handle_ok   = (32'(r_req.block_handle) < TOTAL_BLOCKS);
        o_sts.head_valid  = (head < NULL_LINK);
        o_sts.fresh_avail = (32'(fresh) < BLOCKS_PER_CLASS);
        o_sts.out_free    = !r_rsp_valid || i_rsp_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c]  <= NULL_LINK;
                r_fresh[c] <= '0;
            end
        end else begin
            if (i_cmd.take_pop) begin
                r_head[cls] <= r_link_rd;
            end else if (i_cmd.push) begin
                r_head[cls] <= LINK_W'(free_idx);
            end
            if (i_cmd.take_fresh) begin
                r_fresh[cls] <= fresh + LINK_W'(1);
            end
        end
    end

    // Link memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_link_mem[r_req.block_handle[HANDLE_W-1:0]] <= head;
        end
        if (i_cmd.rd_link) begin
            r_link_rd <= r_link_mem[link_addr];
        end
    end

    assign out_load = i_cmd.take_fresh || i_cmd.take_pop || i_cmd.push || i_cmd.fail;

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (out_load) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (i_cmd.fail) begin
                r_rsp.status      <= i_cmd.fail_status;
                r_rsp.handle      <= '0;
                r_rsp.class_bytes <= '0;
            end else begin
                r_rsp.status      <= ST_OK;
                r_rsp.class_bytes <= cls_bytes;
                if (i_cmd.push) begin
                    r_rsp.handle <= r_req.block_handle[HANDLE_W-1:0];
                end else if (i_cmd.take_pop) begin
                    r_rsp.handle <= link_addr;
                end else begin
                    r_rsp.handle <= fresh_handle;
                end
            end
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// File: rtl/segregated_free_list_allocator.sv
// Segregated free-list allocator: one response beat for every request beat.
// A free request, a fresh allocate and any failing request pass through
// the accepting state and the decode state and load the result register
// from the decode state; an allocate served from a free list passes on to
// the pop state and loads the result from there, because the popped
// block's link is read from the synchronous link memory before the class
// head can move. The result sits in an output register, so the next
// request is taken while it waits; a request stalls only when that
// register is still full at its commit. The link memory needs no clearing
// after reset: only links written by earlier frees are ever read.
// Depends on sfla_pkg, sfla_ctrl, sfla_dp and assert_macros.svh.
`include "assert_macros.svh"

module segregated_free_list_allocator import sfla_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    sfla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sfla_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    `SFLA_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_req_valid && o_req_ready) |=> !o_req_ready, "request taken while previous one in flight")
    `SFLA_ASSERT(a_rsp_follows_req, i_clk, i_rst_n, $rose(o_rsp_valid) |-> !$past(o_req_ready), "response raised without a request in work")
    `SFLA_ASSERT(a_fail_is_zero, i_clk, i_rst_n, (o_rsp_valid && o_rsp.status != ST_OK) |-> (o_rsp.handle == '0 && o_rsp.class_bytes == '0), "failed response carries data")
    `SFLA_ASSERT(a_ok_has_bytes, i_clk, i_rst_n, (o_rsp_valid && o_rsp.status == ST_OK) |-> (o_rsp.class_bytes != '0), "ok response without class size")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for segregated_free_list_allocator.
// Predicts each response from a shadow copy of the class lists and bump counters.
// Depends on sfla_pkg and the allocator RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sfla_pkg::*;

    typedef struct {
        t_req req;
        t_rsp rsp;
    } t_beat;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req       = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_rsp o_rsp;

    // Shadow allocator state
    logic [LINK_W-1:0] arena_head [NUM_CLASSES];
    logic [LINK_W-1:0] fresh_used [NUM_CLASSES];
    logic [LINK_W-1:0] link_mem   [TOTAL_BLOCKS];

    t_beat               req_backlog [$];
    t_rsp                rsp_due     [$];
    logic [HANDLE_W-1:0] live_handles[$];
    t_rsp                req_expect;
    int unsigned         req_wait    = 0;
    int unsigned         rsp_wait    = 0;
    bit                  req_steady  = 1'b0;
    bit                  rsp_steady  = 1'b0;
    int unsigned         n_counted   = 0;
    int unsigned         mismatches  = 0;

    segregated_free_list_allocator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_rsp serve_request(input t_req r);
        t_rsp        rsp;
        int unsigned cls;
        int unsigned idx;
        int unsigned h;
        rsp.status      = ST_OK;
        rsp.handle      = '0;
        rsp.class_bytes = '0;
        idx             = 0;
        if (r.opcode == OP_ALLOC) begin
            cls = (int'(r.request_size) + CLASS_STEP - 1) / CLASS_STEP;
            if (r.request_size == 0 || cls > NUM_CLASSES) begin
                rsp.status = ST_BAD_SIZE;
            end else begin
                cls = cls - 1;
                // freed blocks first, then untouched ones in address order
                if (arena_head[cls] < NULL_LINK) begin
                    idx             = arena_head[cls];
                    arena_head[cls] = link_mem[cls * BLOCKS_PER_CLASS + idx];
                end else if (fresh_used[cls] < BLOCKS_PER_CLASS) begin
                    idx             = fresh_used[cls];
                    fresh_used[cls] = fresh_used[cls] + 1'b1;
                end else begin
                    rsp.status = ST_EXHAUSTED;
                end
                if (rsp.status == ST_OK) begin
                    rsp.handle      = HANDLE_W'(cls * BLOCKS_PER_CLASS + idx);
                    rsp.class_bytes = BYTES_W'((cls + 1) * CLASS_STEP);
                end
            end
        end else begin
            h = r.block_handle;
            if (h >= TOTAL_BLOCKS) begin
                rsp.status = ST_IGNORED;
            end else begin
                cls             = h / BLOCKS_PER_CLASS;
                idx             = h % BLOCKS_PER_CLASS;
                link_mem[h]     = arena_head[cls];
                arena_head[cls] = LINK_W'(idx);
                rsp.handle      = HANDLE_W'(h);
                rsp.class_bytes = BYTES_W'((cls + 1) * CLASS_STEP);
            end
        end
        return rsp;
    endfunction

    task automatic add_beat(input t_opcode op, input int unsigned size, input int unsigned hdl);
        t_beat b;
        int    k;
        b.req.opcode       = op;
        b.req.request_size = REQ_SIZE_W'(size);
        b.req.block_handle = REQ_HDL_W'(hdl);
        b.rsp              = serve_request(b.req);
        if (b.rsp.status == ST_OK) begin
            if (op == OP_ALLOC) begin
                live_handles.push_back(b.rsp.handle);
            end else begin
                for (k = 0; k < live_handles.size(); k++) begin
                    if (live_handles[k] == b.rsp.handle) begin
                        live_handles.delete(k);
                        break;
                    end
                end
            end
        end
        if (b.rsp.status != ST_IGNORED) n_counted++;
        req_backlog.push_back(b);
    endtask

    // Stray frees are held back where a list must stay acyclic.
    task automatic add_mixed_beat(input bit allow_stray);
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(0, 99);
        if (pick < 75 && (pick < 45 || live_handles.size() == 0)) begin
            add_beat(OP_ALLOC, $urandom_range(1, MAX_BYTES), $urandom);
        end else if (pick < 75) begin
            k = $urandom_range(0, live_handles.size() - 1);
            add_beat(OP_FREE, $urandom_range(0, 4095), live_handles[k]);
        end else if (pick < 85 && allow_stray) begin
            add_beat(OP_FREE, $urandom_range(0, 4095), $urandom_range(0, 32767));
        end else if (pick < 85) begin
            add_beat(OP_FREE, $urandom_range(0, 4095), $urandom_range(TOTAL_BLOCKS, 32767));
        end else begin
            add_beat(OP_ALLOC, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_BYTES + 1, 4095),
                     $urandom);
        end
    endtask

    task automatic drain_all();
        while (req_backlog.size() != 0 || i_req_valid || rsp_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic int unsigned draw_idle(input bit steady);
        return steady ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    task automatic check_response(input t_rsp got);
        t_rsp want;
        if (rsp_due.size() == 0) begin
            note_error($sformatf("response with nothing outstanding: status %0d handle %0d bytes %0d",
                                 got.status, got.handle, got.class_bytes));
        end else begin
            want = rsp_due.pop_front();
            if (got.status != want.status)
                note_error($sformatf("status: expected %0d, got %0d", want.status, got.status));
            if (got.handle != want.handle)
                note_error($sformatf("handle: expected %0d, got %0d", want.handle, got.handle));
            if (got.class_bytes != want.class_bytes)
                note_error($sformatf("class_bytes: expected %0d, got %0d",
                                     want.class_bytes, got.class_bytes));
        end
    endtask

    // Request driver: hold each beat until accepted, then idle for the drawn gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
            req_wait    <= 0;
        end else begin
            if (i_req_valid && o_req_ready) rsp_due.push_back(req_expect);
            if (!i_req_valid || o_req_ready) begin
                if (req_wait != 0) begin
                    i_req_valid <= 1'b0;
                    req_wait    <= req_wait - 1;
                end else if (req_backlog.size() != 0) begin
                    i_req       <= req_backlog[0].req;
                    req_expect  <= req_backlog[0].rsp;
                    void'(req_backlog.pop_front());
                    i_req_valid <= 1'b1;
                    req_wait    <= draw_idle(req_steady);
                    if ($urandom_range(0, 49) == 0) req_steady <= !req_steady;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor with random back-pressure.
    always @(posedge i_clk) begin : rsp_sink
        int unsigned stall;
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
            rsp_wait    <= 0;
        end else if (o_rsp_valid && i_rsp_ready) begin
            check_response(o_rsp);
            stall = draw_idle(rsp_steady);
            if ($urandom_range(0, 49) == 0) rsp_steady <= !rsp_steady;
            rsp_wait    <= stall;
            i_rsp_ready <= (stall == 0);
        end else if (rsp_wait != 0) begin
            rsp_wait    <= rsp_wait - 1;
            i_rsp_ready <= (rsp_wait == 1);
        end else begin
            i_rsp_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        int unsigned hot;
        int unsigned guard;
        int          k;
        for (k = 0; k < NUM_CLASSES; k++) begin
            arena_head[k] = NULL_LINK;
            fresh_used[k] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // size limits
        add_beat(OP_ALLOC, 0, $urandom);
        add_beat(OP_ALLOC, MAX_BYTES + 1, $urandom);
        add_beat(OP_ALLOC, 4095, 32767);
        // fresh blocks at both ends of the class range
        add_beat(OP_ALLOC, 1, 0);
        add_beat(OP_ALLOC, 8, $urandom);
        add_beat(OP_ALLOC, 9, $urandom);
        add_beat(OP_ALLOC, MAX_BYTES, $urandom);
        add_beat(OP_ALLOC, MAX_BYTES - 7, $urandom);
        // push two, pop them back in LIFO order, then fall back to fresh
        add_beat(OP_FREE, 4095, 0);
        add_beat(OP_FREE, $urandom_range(0, 4095), 1);
        add_beat(OP_ALLOC, 5, $urandom);
        add_beat(OP_ALLOC, 3, $urandom);
        add_beat(OP_ALLOC, 2, $urandom);
        // stray free of a never-granted last block, then pop it
        add_beat(OP_FREE, $urandom_range(0, 4095), TOTAL_BLOCKS - 1);
        add_beat(OP_ALLOC, MAX_BYTES, $urandom);
        // handles outside the arenas
        add_beat(OP_FREE, $urandom_range(0, 4095), TOTAL_BLOCKS);
        add_beat(OP_FREE, 0, 32767);
        // double free: the same block comes back twice
        add_beat(OP_FREE, $urandom_range(0, 4095), (NUM_CLASSES - 1) * BLOCKS_PER_CLASS + 1);
        add_beat(OP_FREE, $urandom_range(0, 4095), (NUM_CLASSES - 1) * BLOCKS_PER_CLASS + 1);
        add_beat(OP_ALLOC, MAX_BYTES - 3, $urandom);
        add_beat(OP_ALLOC, MAX_BYTES - 3, $urandom);
        add_beat(OP_FREE, $urandom_range(0, 4095), BLOCKS_PER_CLASS);
        add_beat(OP_ALLOC, 16, $urandom);

        // hold off until every response is back
        drain_all();

        n_counted = 0;
        repeat (150) add_mixed_beat(1'b0);

        // run one class dry; the top class carries a self-linked block by now
        hot   = $urandom_range(0, NUM_CLASSES - 2);
        guard = 0;
        while (!(arena_head[hot] == NULL_LINK && fresh_used[hot] == BLOCKS_PER_CLASS)
               && guard < 4000) begin
            if ($urandom_range(0, 99) < 92)
                add_beat(OP_ALLOC, $urandom_range(hot * CLASS_STEP + 1, (hot + 1) * CLASS_STEP),
                         $urandom);
            else
                add_mixed_beat(1'b0);
            guard++;
        end
        repeat (3) add_beat(OP_ALLOC, (hot + 1) * CLASS_STEP, $urandom);
        add_beat(OP_FREE, $urandom_range(0, 4095), hot * BLOCKS_PER_CLASS);
        add_beat(OP_FREE, $urandom_range(0, 4095), hot * BLOCKS_PER_CLASS + BLOCKS_PER_CLASS - 1);
        repeat (3) add_beat(OP_ALLOC, hot * CLASS_STEP + 1, $urandom);

        drain_all();

        while (n_counted < 1350) add_mixed_beat(1'b1);

        drain_all();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
